[hdl/uwb_signal_power_nlos_estimator_macros.svh]
// Assertion macros for the receive power estimator.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef UWB_SIGNAL_POWER_NLOS_ESTIMATOR_MACROS_SVH
`define UWB_SIGNAL_POWER_NLOS_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USPNE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define USPNE_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/uspne_pkg.sv]
// Shared widths, constants and types of the receive power estimator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uspne_pkg;

   // Field widths
   localparam int CNT_W      = 12;
   localparam int AMP_W      = 22;
   localparam int AMP_FRAC   = 2;
   localparam int AMP_INT_W  = AMP_W - AMP_FRAC;
   localparam int CP_W       = 32;
   localparam int GAIN_W     = 3;
   localparam int PWR_W      = 17;
   localparam int PC_W       = 5;
   localparam int THR_W      = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   // Internal widths
   localparam int SQ_W       = 2 * AMP_INT_W;
   localparam int FSUM_W     = SQ_W + 2;
   localparam int NN_W       = 2 * CNT_W;
   localparam int LOG_FRAC   = 16;
   localparam int LOG_INT_W  = 6;
   localparam int LOG_W      = LOG_INT_W + LOG_FRAC;
   localparam int MANT_W     = 31;

   // Level arithmetic
   localparam int DEF_FRAC_BITS    = 8;
   localparam int PRF_CODE_SPLIT   = 8;
   localparam int ALPHA_HI_TENTHS  = 1217;
   localparam int ALPHA_LO_TENTHS  = 1138;
   localparam int RX_OFFSET_TENTHS = 632;
   localparam int GAIN_DB_STEP     = 6;
   localparam int DB_PER_LOG2_Q16  = 197283;
   localparam int DB_K_W           = 19;
   localparam int PWR_MAX          = 65535;
   localparam int PWR_MIN          = -65536;

   // Register reset values
   localparam logic [PC_W-1:0]  PC_RESET  = PC_W'(9);
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(12);

   // Pipeline layout
   localparam int FRONT_STG = 2;
   localparam int LOG_STG   = LOG_FRAC + 1;
   localparam int DB_STG    = 3;
   localparam int NUM_STG   = FRONT_STG + LOG_STG + DB_STG;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREAMBLE_CODE  = CSR_IDX_W'(0),
      CSR_NLOS_THRESHOLD = CSR_IDX_W'(1)
   } csr_idx_type;

   // Fields that ride along the log pipeline
   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic              invalid;
   } side_type;

endpackage

[hdl/uspne_front.sv]
// Front stages: squares of count and amplitudes, then the amplitude power sum.
// Depends on uspne_pkg.
`timescale 1ns / 1ps

module uspne_front (
   input  logic                           clock,
   input  logic [1:0]                     stage_en,
   input  logic [uspne_pkg::CNT_W-1:0]    accum_count,
   input  logic [uspne_pkg::AMP_W-1:0]    fp_amp_one,
   input  logic [uspne_pkg::AMP_W-1:0]    fp_amp_two,
   input  logic [uspne_pkg::AMP_W-1:0]    fp_amp_three,
   input  logic [uspne_pkg::CP_W-1:0]     channel_power,
   input  logic [uspne_pkg::GAIN_W-1:0]   gain_decision,
   output logic [uspne_pkg::FSUM_W-1:0]   fsum,
   output logic [uspne_pkg::NN_W-1:0]     nn,
   output logic [uspne_pkg::CP_W-1:0]     cp,
   output uspne_pkg::side_type            side
);
   import uspne_pkg::*;

   logic [AMP_INT_W-1:0] a1, a2, a3;
   logic [SQ_W-1:0]      sq1_in, sq2_in, sq3_in;
   logic [SQ_W-1:0]      sq1_ff, sq2_ff, sq3_ff;
   logic [NN_W-1:0]      nn_in, nn0_ff, nn1_ff;
   logic [CP_W-1:0]      cp0_ff, cp1_ff;
   logic [FSUM_W-1:0]    fsum_in, fsum_ff;
   side_type             side_in, side0_ff, side1_ff;

   // drop the two fractional amplitude bits
   assign a1 = fp_amp_one[AMP_W-1:AMP_FRAC];
   assign a2 = fp_amp_two[AMP_W-1:AMP_FRAC];
   assign a3 = fp_amp_three[AMP_W-1:AMP_FRAC];

   always_comb begin
      sq1_in = a1 * a1;
      sq2_in = a2 * a2;
      sq3_in = a3 * a3;
      nn_in  = accum_count * accum_count;
      side_in.gain    = gain_decision;
      side_in.invalid = (accum_count == '0) || (channel_power == '0) ||
                        ((a1 == '0) && (a2 == '0) && (a3 == '0));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq1_ff   <= sq1_in;
         sq2_ff   <= sq2_in;
         sq3_ff   <= sq3_in;
         nn0_ff   <= nn_in;
         cp0_ff   <= channel_power;
         side0_ff <= side_in;
      end
   end

   assign fsum_in = FSUM_W'(sq1_ff) + FSUM_W'(sq2_ff) + FSUM_W'(sq3_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         fsum_ff  <= fsum_in;
         nn1_ff   <= nn0_ff;
         cp1_ff   <= cp0_ff;
         side1_ff <= side0_ff;
      end
   end

   assign fsum = fsum_ff;
   assign nn   = nn1_ff;
   assign cp   = cp1_ff;
   assign side = side1_ff;

endmodule

[hdl/uspne_log2.sv]
// Pipelined log2 in Q16: normalize stage, then one squaring stage per fraction bit.
// Depends on uspne_pkg.
`timescale 1ns / 1ps

module uspne_log2 #(
   parameter int IN_W = uspne_pkg::FSUM_W
) (
   input  logic                          clock,
   input  logic [uspne_pkg::LOG_FRAC:0]  stage_en,
   input  logic [IN_W-1:0]               x,
   output logic [uspne_pkg::LOG_W-1:0]   log_out
);
   import uspne_pkg::*;

   localparam int E_W  = $clog2(IN_W);
   localparam int NW   = (IN_W > MANT_W) ? IN_W : MANT_W;
   localparam int SH_W = $clog2(NW);

   logic [E_W-1:0]      e_in;
   logic [NW-1:0]       xe;
   logic [NW-1:0]       sh;
   logic [MANT_W-1:0]   m_in;

   logic [MANT_W-1:0]   m_ff    [LOG_FRAC+1];
   logic [E_W-1:0]      e_ff    [LOG_FRAC+1];
   logic [LOG_FRAC-1:0] frac_ff [LOG_FRAC+1];

   // top set bit, then left-justify into Q30
   always_comb begin
      e_in = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (x[i]) begin
            e_in = E_W'(i);
         end
      end
      xe   = NW'(x);
      sh   = xe << (SH_W'(NW - 1) - SH_W'(e_in));
      m_in = sh[NW-1 -: MANT_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         m_ff[0]    <= m_in;
         e_ff[0]    <= e_in;
         frac_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     t;

      assign sq = m_ff[k-1] * m_ff[k-1];
      assign t  = sq[2*MANT_W-1:MANT_W-1];

      // a square at or above two yields a one bit and is halved
      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            m_ff[k]    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
            frac_ff[k] <= {frac_ff[k-1][LOG_FRAC-2:0], t[MANT_W]};
            e_ff[k]    <= e_ff[k-1];
         end
      end
   end

   assign log_out = LOG_W'({e_ff[LOG_FRAC], frac_ff[LOG_FRAC]});

endmodule

[hdl/uspne_db.sv]
// Back stages: log difference to dB, level offsets, saturation and NLOS decision.
// Depends on uspne_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "uwb_signal_power_nlos_estimator_macros.svh"

module uspne_db #(
   parameter int FRAC_BITS = uspne_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [2:0]                          stage_en,
   input  logic                                out_valid,
   input  logic [uspne_pkg::LOG_W-1:0]         log_cp,
   input  logic [uspne_pkg::LOG_W-1:0]         log_fsum,
   input  logic [uspne_pkg::LOG_W-1:0]         log_nn,
   input  uspne_pkg::side_type                 side_in,
   input  logic [uspne_pkg::PC_W-1:0]          preamble_code,
   input  logic [uspne_pkg::THR_W-1:0]         nlos_threshold,
   output logic signed [uspne_pkg::PWR_W-1:0]  rx_power,
   output logic signed [uspne_pkg::PWR_W-1:0]  first_path_power,
   output logic                                nlos_flag,
   output logic                                invalid
);
   import uspne_pkg::*;

   localparam int LVL_W = FRAC_BITS + 10;
   localparam int DIF_W = LVL_W + 1;
   localparam int SHIFT = 32 - FRAC_BITS;
   localparam int D_W   = LOG_W + 1;
   localparam int P_W   = D_W + DB_K_W;
   localparam int GM_W  = 6;

   localparam logic signed [DB_K_W-1:0] DB_K  = DB_K_W'(DB_PER_LOG2_Q16);
   localparam logic signed [P_W-1:0]    ROUND = P_W'(64'd1 << (SHIFT - 1));
   localparam logic signed [LVL_W-1:0]  ALPHA_HI_Q =
      LVL_W'(((ALPHA_HI_TENTHS << FRAC_BITS) + 5) / 10);
   localparam logic signed [LVL_W-1:0]  ALPHA_LO_Q =
      LVL_W'(((ALPHA_LO_TENTHS << FRAC_BITS) + 5) / 10);
   localparam logic signed [LVL_W-1:0]  RX_OFS_Q =
      LVL_W'(((RX_OFFSET_TENTHS << FRAC_BITS) + 5) / 10);

   // stage 0
   logic signed [D_W-1:0]   d_rx, d_fp;
   logic signed [P_W-1:0]   p_rx_in, p_fp_in, p_rx_ff, p_fp_ff;
   logic signed [LVL_W-1:0] alpha_q, gain_q;
   logic [GM_W-1:0]         gm;
   logic signed [LVL_W-1:0] base_rx_in, base_fp_in, base_rx_ff, base_fp_ff;
   side_type                side0_ff;

   // stage 1
   logic signed [P_W-1:0]   v_rx, v_fp;
   logic signed [LVL_W-1:0] db_rx, db_fp;
   logic signed [LVL_W-1:0] rx_lvl_in, fp_lvl_in, rx_lvl_ff, fp_lvl_ff;
   side_type                side1_ff;

   // stage 2
   logic signed [31:0]      rx_w, fp_w;
   logic signed [DIF_W-1:0] diff, thr_q;
   logic signed [PWR_W-1:0] rx_sat, fp_sat;
   logic signed [PWR_W-1:0] rx_power_ff, fp_power_ff;
   logic                    nlos_ff, invalid_ff;

   always_comb begin
      d_rx    = $signed({1'b0, log_cp})   - $signed({1'b0, log_nn});
      d_fp    = $signed({1'b0, log_fsum}) - $signed({1'b0, log_nn});
      p_rx_in = d_rx * DB_K;
      p_fp_in = d_fp * DB_K;
      alpha_q = (preamble_code > PC_W'(PRF_CODE_SPLIT)) ? -ALPHA_HI_Q : -ALPHA_LO_Q;
      gm      = GM_W'(side_in.gain) * GM_W'(GAIN_DB_STEP);
      gain_q  = LVL_W'(gm) << FRAC_BITS;
      base_fp_in = alpha_q + gain_q;
      base_rx_in = alpha_q + gain_q + RX_OFS_Q;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         p_rx_ff    <= p_rx_in;
         p_fp_ff    <= p_fp_in;
         base_rx_ff <= base_rx_in;
         base_fp_ff <= base_fp_in;
         side0_ff   <= side_in;
      end
   end

   // round to nearest, ties toward plus infinity
   always_comb begin
      v_rx      = p_rx_ff + ROUND;
      v_fp      = p_fp_ff + ROUND;
      db_rx     = LVL_W'(v_rx >>> SHIFT);
      db_fp     = LVL_W'(v_fp >>> SHIFT);
      rx_lvl_in = db_rx + base_rx_ff;
      fp_lvl_in = db_fp + base_fp_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rx_lvl_ff <= rx_lvl_in;
         fp_lvl_ff <= fp_lvl_in;
         side1_ff  <= side0_ff;
      end
   end

   // flag uses the unsaturated levels
   always_comb begin
      rx_w  = 32'(rx_lvl_ff);
      fp_w  = 32'(fp_lvl_ff);
      diff  = DIF_W'(rx_lvl_ff) - DIF_W'(fp_lvl_ff);
      thr_q = DIF_W'({nlos_threshold, {FRAC_BITS{1'b0}}});
      if (rx_w > PWR_MAX) begin
         rx_sat = PWR_W'(PWR_MAX);
      end else if (rx_w < PWR_MIN) begin
         rx_sat = PWR_W'(PWR_MIN);
      end else begin
         rx_sat = rx_w[PWR_W-1:0];
      end
      if (fp_w > PWR_MAX) begin
         fp_sat = PWR_W'(PWR_MAX);
      end else if (fp_w < PWR_MIN) begin
         fp_sat = PWR_W'(PWR_MIN);
      end else begin
         fp_sat = fp_w[PWR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         if (side1_ff.invalid) begin
            rx_power_ff <= '0;
            fp_power_ff <= '0;
            nlos_ff     <= 1'b0;
            invalid_ff  <= 1'b1;
         end else begin
            rx_power_ff <= rx_sat;
            fp_power_ff <= fp_sat;
            nlos_ff     <= (diff > thr_q);
            invalid_ff  <= 1'b0;
         end
      end
   end

   assign rx_power         = rx_power_ff;
   assign first_path_power = fp_power_ff;
   assign nlos_flag        = nlos_ff;
   assign invalid          = invalid_ff;

   `USPNE_ASSERT_IMP(a_invalid_zeroes, clock, reset, out_valid && invalid, (rx_power == '0) && (first_path_power == '0) && !nlos_flag, "invalid result carries nonzero fields")

endmodule

[hdl/uwb_signal_power_nlos_estimator.sv]
// UWB receive power and first path power estimator with NLOS decision.
//
// Usage: present one receiver diagnostic record on the req_ channel
// (valid/ready); each accepted request yields exactly one response on the
// rsp_ channel carrying rx_power and first_path_power (signed dB with
// FRAC_BITS fraction bits, saturated to 17 bits), nlos_flag and invalid.
// Registers are written on the csr_ channel (index 0 preamble code,
// index 1 NLOS threshold in whole dB); csr_ready is always high, and
// writes are meant to land only while no request is in flight.
//
// Throughput: one request per cycle unless a full pipeline is held by a low
// rsp_ready. The depth comes from the log2 units, which spend one pipeline
// stage and one 31x31 multiplier per fraction bit (16 stages plus a normalize
// stage), plus two front and three back stages.
//
// Reset clears every pipeline valid bit and loads preamble code 9 and
// threshold 12; no clearing pass is needed. When rsp_ready is low, the run
// of filled stages at the output holds and the stages before it keep filling;
// req_ready falls only once all 22 stages hold a request.
//
// Depends on uspne_pkg, uspne_front, uspne_log2, uspne_db and the macro header.
`timescale 1ns / 1ps
`include "uwb_signal_power_nlos_estimator_macros.svh"

module uwb_signal_power_nlos_estimator #(
   parameter int FRAC_BITS = uspne_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [uspne_pkg::CNT_W-1:0]         req_accum_count,
   input  logic [uspne_pkg::AMP_W-1:0]         req_fp_amp_one,
   input  logic [uspne_pkg::AMP_W-1:0]         req_fp_amp_two,
   input  logic [uspne_pkg::AMP_W-1:0]         req_fp_amp_three,
   input  logic [uspne_pkg::CP_W-1:0]          req_channel_power,
   input  logic [uspne_pkg::GAIN_W-1:0]        req_gain_decision,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [uspne_pkg::PWR_W-1:0]  rsp_rx_power,
   output logic signed [uspne_pkg::PWR_W-1:0]  rsp_first_path_power,
   output logic                                rsp_nlos_flag,
   output logic                                rsp_invalid,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uspne_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uspne_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import uspne_pkg::*;

   localparam int LOG_LO = FRONT_STG;
   localparam int LOG_HI = FRONT_STG + LOG_STG - 1;

   logic [NUM_STG-1:0] valid_ff;
   logic [NUM_STG-1:0] rdy;
   logic [PC_W-1:0]    preamble_ff;
   logic [THR_W-1:0]   threshold_ff;

   logic [FSUM_W-1:0]  fsum;
   logic [NN_W-1:0]    nn;
   logic [CP_W-1:0]    cp;
   side_type           front_side;
   side_type           side_ff [LOG_STG];
   logic [LOG_W-1:0]   log_cp, log_fsum, log_nn;

   // a stage advances when it is empty or everything after it can move
   for (genvar i = 0; i < NUM_STG; i++) begin : g_rdy
      assign rdy[i] = rsp_ready || !(&valid_ff[NUM_STG-1:i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STG; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[NUM_STG-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff  <= PC_RESET;
         threshold_ff <= THR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PREAMBLE_CODE:  preamble_ff  <= csr_wdata[PC_W-1:0];
            CSR_NLOS_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   uspne_front u_front (
      .clock         (clock),
      .stage_en      (rdy[FRONT_STG-1:0]),
      .accum_count   (req_accum_count),
      .fp_amp_one    (req_fp_amp_one),
      .fp_amp_two    (req_fp_amp_two),
      .fp_amp_three  (req_fp_amp_three),
      .channel_power (req_channel_power),
      .gain_decision (req_gain_decision),
      .fsum          (fsum),
      .nn            (nn),
      .cp            (cp),
      .side          (front_side)
   );

   uspne_log2 #(.IN_W(CP_W)) u_log_cp (
      .clock    (clock),
      .stage_en (rdy[LOG_HI:LOG_LO]),
      .x        (cp),
      .log_out  (log_cp)
   );

   uspne_log2 #(.IN_W(FSUM_W)) u_log_fsum (
      .clock    (clock),
      .stage_en (rdy[LOG_HI:LOG_LO]),
      .x        (fsum),
      .log_out  (log_fsum)
   );

   uspne_log2 #(.IN_W(NN_W)) u_log_nn (
      .clock    (clock),
      .stage_en (rdy[LOG_HI:LOG_LO]),
      .x        (nn),
      .log_out  (log_nn)
   );

   // gain and invalid flag travel alongside the log stages
   always_ff @(posedge clock) begin
      if (rdy[LOG_LO]) begin
         side_ff[0] <= front_side;
      end
      for (int j = 1; j < LOG_STG; j++) begin
         if (rdy[LOG_LO+j]) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   uspne_db #(.FRAC_BITS(FRAC_BITS)) u_db (
      .clock            (clock),
      .reset            (reset),
      .stage_en         (rdy[NUM_STG-1:NUM_STG-DB_STG]),
      .out_valid        (valid_ff[NUM_STG-1]),
      .log_cp           (log_cp),
      .log_fsum         (log_fsum),
      .log_nn           (log_nn),
      .side_in          (side_ff[LOG_STG-1]),
      .preamble_code    (preamble_ff),
      .nlos_threshold   (threshold_ff),
      .rx_power         (rsp_rx_power),
      .first_path_power (rsp_first_path_power),
      .nlos_flag        (rsp_nlos_flag),
      .invalid          (rsp_invalid)
   );

   `USPNE_ASSERT_IMP(a_bubble_takes_request, clock, reset, !(&valid_ff), req_ready, "pipeline has a free stage but refuses a request")
   `USPNE_ASSERT_IMP(a_full_stall_blocks, clock, reset, (&valid_ff) && !rsp_ready, !req_ready, "full stalled pipeline accepts a request")
   `USPNE_ASSERT_NXT(a_full_stall_holds, clock, reset, (&valid_ff) && !rsp_ready, &valid_ff, "stalled pipeline lost a request")

endmodule

[tb/uwb_signal_power_nlos_estimator_tb.sv]
// Testbench for uwb_signal_power_nlos_estimator: drives diagnostic records and register writes,
// predicts each response in fixed point and compares it field by field.
// Depends on uspne_pkg and the estimator RTL; needs no files or arguments.
`timescale 1ns / 1ps

module uwb_signal_power_nlos_estimator_tb;
   import uspne_pkg::*;

   localparam int FRAC_BITS      = DEF_FRAC_BITS;
   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 44;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_HOLD  = 120;
   localparam int PRESSURE_ITEMS = 60;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 220;
   localparam int TAIL_ITEMS     = 200;
   localparam int MAX_PRINTED    = 40;

   typedef struct packed {
      logic [CNT_W-1:0]  accum_count;
      logic [AMP_W-1:0]  amp_one;
      logic [AMP_W-1:0]  amp_two;
      logic [AMP_W-1:0]  amp_three;
      logic [CP_W-1:0]   channel_power;
      logic [GAIN_W-1:0] gain_decision;
   } diag_record_type;

   typedef struct packed {
      logic signed [PWR_W-1:0] rx_power;
      logic signed [PWR_W-1:0] first_path_power;
      logic                    nlos_flag;
      logic                    invalid;
   } power_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CNT_W-1:0]        req_accum_count;
   logic [AMP_W-1:0]        req_fp_amp_one;
   logic [AMP_W-1:0]        req_fp_amp_two;
   logic [AMP_W-1:0]        req_fp_amp_three;
   logic [CP_W-1:0]         req_channel_power;
   logic [GAIN_W-1:0]       req_gain_decision;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [PWR_W-1:0] rsp_rx_power;
   logic signed [PWR_W-1:0] rsp_first_path_power;
   logic                    rsp_nlos_flag;
   logic                    rsp_invalid;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // predictor copy of the registers
   logic [PC_W-1:0]  pcode_model = PC_RESET;
   logic [THR_W-1:0] thr_model   = THR_RESET;

   power_result_type expected_levels[$];

   bit idle_on         = 1'b1;
   int pressure_asked  = 0;
   int pressure_served = 0;
   int mismatch_count  = 0;
   int sent_count      = 0;
   int rsp_count       = 0;
   int invalid_count   = 0;
   int nlos_count      = 0;
   int csr_writes      = 0;
   int req_stall_cycles = 0;
   int quiet_cycles    = 0;

   uwb_signal_power_nlos_estimator #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_accum_count      (req_accum_count),
      .req_fp_amp_one       (req_fp_amp_one),
      .req_fp_amp_two       (req_fp_amp_two),
      .req_fp_amp_three     (req_fp_amp_three),
      .req_channel_power    (req_channel_power),
      .req_gain_decision    (req_gain_decision),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rx_power         (rsp_rx_power),
      .rsp_first_path_power (rsp_first_path_power),
      .rsp_nlos_flag        (rsp_nlos_flag),
      .rsp_invalid          (rsp_invalid),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // log2 in Q16: top set bit, then one fraction bit per squaring of the Q30 mantissa
   function automatic longint log2_fixed(input longint unsigned x);
      int unsigned     e;
      longint unsigned m;
      longint          frac;
      int              i;
      e = 63;
      while (e > 0 && x[e] == 1'b0) e--;
      if (e >= 30) m = x >> (e - 30);
      else m = x << (30 - e);
      frac = 0;
      for (i = 0; i < LOG_FRAC; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(e) << LOG_FRAC) | frac;
   endfunction

   // Q16 log2 difference to dB in Q FRAC_BITS, rounded half up
   function automatic longint db_from_log2(input longint d);
      longint v;
      v = d * DB_PER_LOG2_Q16 + (longint'(1) <<< (31 - FRAC_BITS));
      return v >>> (32 - FRAC_BITS);
   endfunction

   function automatic longint tenths_to_q(input int tenths);
      return ((longint'(tenths) << FRAC_BITS) + 5) / 10;
   endfunction

   function automatic logic [PWR_W-1:0] clamp_level(input longint v);
      if (v > PWR_MAX) v = PWR_MAX;
      if (v < PWR_MIN) v = PWR_MIN;
      return v[PWR_W-1:0];
   endfunction

   function automatic power_result_type predict_levels(input diag_record_type r);
      longint unsigned  n, a1, a2, a3, fsum, cp;
      longint           log_nn, alpha, gain, rx, fp;
      power_result_type res;
      n    = r.accum_count;
      a1   = r.amp_one >> AMP_FRAC;
      a2   = r.amp_two >> AMP_FRAC;
      a3   = r.amp_three >> AMP_FRAC;
      fsum = a1 * a1 + a2 * a2 + a3 * a3;
      cp   = r.channel_power;
      res  = '0;
      if (n == 0 || cp == 0 || fsum == 0) begin
         res.invalid = 1'b1;
         return res;
      end
      log_nn = log2_fixed(n * n);
      alpha  = (pcode_model > PRF_CODE_SPLIT) ? -tenths_to_q(ALPHA_HI_TENTHS)
                                              : -tenths_to_q(ALPHA_LO_TENTHS);
      gain   = longint'(GAIN_DB_STEP * r.gain_decision) << FRAC_BITS;
      rx = db_from_log2(log2_fixed(cp) - log_nn) + alpha + tenths_to_q(RX_OFFSET_TENTHS) + gain;
      fp = db_from_log2(log2_fixed(fsum) - log_nn) + alpha + gain;
      res.rx_power         = clamp_level(rx);
      res.first_path_power = clamp_level(fp);
      // flag uses the levels before clamping
      res.nlos_flag        = ((rx - fp) > (longint'(thr_model) << FRAC_BITS));
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // random value whose top set bit lands anywhere in the field
   function automatic logic [63:0] rand_span(input int width);
      int          len;
      logic [63:0] mask;
      len  = $urandom_range(width, 0);
      mask = (64'd1 << len) - 64'd1;
      return {$urandom, $urandom} & mask;
   endfunction

   function automatic diag_record_type make_record(input logic [CNT_W-1:0] n,
                                                   input logic [AMP_W-1:0] f1,
                                                   input logic [AMP_W-1:0] f2,
                                                   input logic [AMP_W-1:0] f3,
                                                   input logic [CP_W-1:0] cp,
                                                   input logic [GAIN_W-1:0] g);
      diag_record_type r;
      r.accum_count   = n;
      r.amp_one       = f1;
      r.amp_two       = f2;
      r.amp_three     = f3;
      r.channel_power = cp;
      r.gain_decision = g;
      return r;
   endfunction

   function automatic diag_record_type random_record();
      diag_record_type r;
      r.accum_count = ($urandom_range(0, 15) == 0) ? '1 : CNT_W'(rand_span(CNT_W));
      if ($urandom_range(0, 19) == 0) begin
         // all three amplitudes vanish once the fraction bits are dropped
         r.amp_one   = AMP_W'($urandom_range(0, 3));
         r.amp_two   = AMP_W'($urandom_range(0, 3));
         r.amp_three = AMP_W'($urandom_range(0, 3));
      end else begin
         r.amp_one   = AMP_W'(rand_span(AMP_W));
         r.amp_two   = AMP_W'(rand_span(AMP_W));
         r.amp_three = AMP_W'(rand_span(AMP_W));
      end
      r.channel_power = ($urandom_range(0, 31) == 0) ? '0 : CP_W'(rand_span(CP_W));
      r.gain_decision = GAIN_W'($urandom_range(0, 7));
      return r;
   endfunction

   task automatic send_record(input diag_record_type r);
      req_valid         <= 1'b1;
      req_accum_count   <= r.accum_count;
      req_fp_amp_one    <= r.amp_one;
      req_fp_amp_two    <= r.amp_two;
      req_fp_amp_three  <= r.amp_three;
      req_channel_power <= r.channel_power;
      req_gain_decision <= r.gain_decision;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_levels.push_back(predict_levels(r));
      sent_count++;
   endtask

   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_batch(input int count);
      repeat (count) begin
         send_record(random_record());
         sender_gap();
      end
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_PREAMBLE_CODE) pcode_model = data[PC_W-1:0];
      else if (idx == CSR_NLOS_THRESHOLD) thr_model = data[THR_W-1:0];
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_unmapped();
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, CSR_NLOS_THRESHOLD + 1)),
                CSR_DATA_W'($urandom));
   endtask

   // drain the pipeline before touching the registers
   task automatic set_config(input logic [CSR_DATA_W-1:0] pc_data,
                             input logic [CSR_DATA_W-1:0] thr_data);
      wait_for_responses();
      write_reg(CSR_PREAMBLE_CODE, pc_data);
      write_reg(CSR_NLOS_THRESHOLD, thr_data);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_records();
      int g;
      send_record(make_record(0, 1000, 2000, 3000, 32'h1234, 3));
      sender_gap();
      send_record(make_record(64, 1000, 2000, 3000, 0, 3));
      sender_gap();
      send_record(make_record(64, 0, 0, 0, 5000, 3));
      sender_gap();
      send_record(make_record(64, 1, 2, 3, 5000, 3));
      sender_gap();
      send_record(make_record('1, '1, '1, '1, '1, 7));
      sender_gap();
      send_record(make_record(1, 4, 0, 0, 1, 0));
      sender_gap();
      send_record(make_record(1, '1, 0, 0, '1, 7));
      sender_gap();
      send_record(make_record('1, 0, 0, 4, 1, 0));
      sender_gap();
      // channel power 8 and then 4 against the same first path, under the default 12 dB threshold
      send_record(make_record(1, 22'h1000, 0, 0, 8, 2));
      sender_gap();
      send_record(make_record(1, 22'h1000, 0, 0, 4, 2));
      sender_gap();
      send_record(make_record(12'hAAA, 22'h2AAAAA, 22'h155555, 22'h3FFFFC, 32'hAAAA5555, 5));
      sender_gap();
      send_record(make_record(12'h555, 22'h155555, 22'h2AAAAA, 22'h000004, 32'h5555AAAA, 2));
      sender_gap();
      for (g = 0; g < 8; g++) begin
         send_record(make_record(CNT_W'(100 + g * 500), 22'h3_0000, 22'h1_2345, 22'h8888,
                                 32'h0010_0000, GAIN_W'(g)));
         sender_gap();
      end
   endtask

   task automatic test_register_extremes();
      set_config(1, 0);
      send_batch(10);
      set_config(31, 63);
      send_batch(10);
      // split point of the PRF selection
      set_config(CSR_DATA_W'(PRF_CODE_SPLIT), 12);
      send_batch(10);
      set_config(CSR_DATA_W'(PRF_CODE_SPLIT + 1), 1);
      send_batch(10);
      // bits above the register width drop
      set_config(8'hFF, 8'hE0);
      send_batch(10);
      wait_for_responses();
      write_unmapped();
      send_batch(10);
   endtask

   task automatic test_output_backpressure();
      set_config(CSR_DATA_W'($urandom_range(0, 255)), CSR_DATA_W'($urandom_range(0, 255)));
      idle_on = 1'b0;
      pressure_asked++;
      send_batch(PRESSURE_ITEMS);
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      repeat (RANDOM_PHASES) begin
         set_config(CSR_DATA_W'($urandom_range(0, 255)), CSR_DATA_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) write_unmapped();
         send_batch(PHASE_ITEMS);
      end
   endtask

   task automatic test_streaming_tail();
      set_config(CSR_DATA_W'($urandom_range(0, 255)), CSR_DATA_W'($urandom_range(0, 255)));
      idle_on = 1'b0;
      send_batch(TAIL_ITEMS);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t: response %0d %s: got %0d, want %0d", $time, rsp_count, what, got, want);
   endtask

   always @(posedge clock) begin : level_checker
      power_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         rsp_count++;
         if (rsp_invalid === 1'b1) invalid_count++;
         if (rsp_nlos_flag === 1'b1) nlos_count++;
         if (expected_levels.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_rx_power, 0);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_rx_power !== want.rx_power)
               report_mismatch("rx_power", rsp_rx_power, $signed(want.rx_power));
            if (rsp_first_path_power !== want.first_path_power)
               report_mismatch("first_path_power", rsp_first_path_power,
                               $signed(want.first_path_power));
            if (rsp_nlos_flag !== want.nlos_flag)
               report_mismatch("nlos_flag", rsp_nlos_flag, want.nlos_flag);
            if (rsp_invalid !== want.invalid)
               report_mismatch("invalid", rsp_invalid, want.invalid);
         end
      end
   end

   // receiver: short random stalls, plus one long hold-off when asked
   initial begin : result_sink
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (pressure_served != pressure_asked) begin
            rsp_ready <= 1'b0;
            repeat (PRESSURE_HOLD) @(posedge clock);
            pressure_served++;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (req_valid === 1'b1 && req_ready !== 1'b1) req_stall_cycles++;
      if (reset !== 1'b0 || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, expected_levels.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : test_sequence
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_accum_count   <= '0;
      req_fp_amp_one    <= '0;
      req_fp_amp_two    <= '0;
      req_fp_amp_three  <= '0;
      req_channel_power <= '0;
      req_gain_decision <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_records();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      test_streaming_tail();

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d responses (%0d invalid, %0d non-line-of-sight),",
               sent_count, rsp_count, invalid_count, nlos_count);
      $display("%0d register writes and %0d cycles of input stall under output hold-off",
               csr_writes, req_stall_cycles);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
